[src/perspective_point_projector_defines.svh]
// ---------------------------------------------------------------------------
// Perspective point projector assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off in reset.
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_POINT_PROJECTOR_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTOR_DEFINES_SVH

// same-cycle implication
`define PPP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppp: same-cycle check failed");

// next-cycle implication
`define PPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppp: next-cycle check failed");

`endif

[src/ppp_pkg.sv]
// ---------------------------------------------------------------------------
// Perspective point projector package
// Widths, register indexes and transfer payload types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ppp_pkg;

    localparam int COORD_BITS       = 20;
    localparam int BASIS_FRAC_BITS  = 14;
    localparam int BASIS_FIELD_BITS = 16;
    localparam int OUT_FRAC_BITS    = 4;
    localparam int SCREEN_W         = 16;
    localparam int CAM_W            = 3 * COORD_BITS;
    localparam int BASIS_W          = 3 * BASIS_FIELD_BITS;
    localparam int SCALE_W          = 12;
    localparam int MIN_DEPTH_W      = 20;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 64;

    localparam int D_W     = COORD_BITS + 1;
    localparam int MUL_W   = D_W + BASIS_FIELD_BITS;
    localparam int DOT_W   = MUL_W + 2;
    localparam int LIMIT_W = MIN_DEPTH_W + BASIS_FRAC_BITS;
    localparam int PSC_W   = SCALE_W + OUT_FRAC_BITS;
    localparam int PRJ_W   = DOT_W + PSC_W + 1;
    localparam int MAG_W   = PRJ_W - 1;
    localparam int QUOT_W  = SCREEN_W + 2;
    localparam int REM_W   = DOT_W + QUOT_W;
    localparam int RES_W   = QUOT_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_POSITION = 8'd0,
        REG_VIEW_NORMAL  = 8'd1,
        REG_VIEW_UP      = 8'd2,
        REG_VIEW_RIGHT   = 8'd3,
        REG_PROJ_SCALE   = 8'd4,
        REG_CENTER_X     = 8'd5,
        REG_CENTER_Y     = 8'd6,
        REG_MIN_DEPTH    = 8'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y;
        logic                       visible;
    } result_t;

    typedef struct packed {
        logic [CAM_W-1:0]       cam_position;
        logic [BASIS_W-1:0]     view_normal;
        logic [BASIS_W-1:0]     view_up;
        logic [BASIS_W-1:0]     view_right;
        logic [SCALE_W-1:0]     proj_scale;
        logic [SCALE_W-1:0]     center_x;
        logic [SCALE_W-1:0]     center_y;
        logic [MIN_DEPTH_W-1:0] min_depth;
    } cfg_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  rem_y;
        logic [QUOT_W-1:0] quot_x;
        logic [QUOT_W-1:0] quot_y;
        logic [DOT_W-1:0]  den;
        logic              neg_x;
        logic              neg_y;
        logic              ovf_x;
        logic              ovf_y;
        logic              rej;
    } div_t;

endpackage

[src/ppp_front.sv]
// ---------------------------------------------------------------------------
// Projector front end
// Offset, basis dot products, depth test, scale multiply and dividend set-up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  ppp_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  ppp_pkg::point_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ppp_pkg::div_t   out_data
);
    import ppp_pkg::*;

    localparam int NST = 6;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   en;

    logic signed [D_W-1:0]   d_reg [3];
    logic signed [MUL_W-1:0] pn_reg [3];
    logic signed [MUL_W-1:0] pr_reg [3];
    logic signed [MUL_W-1:0] pu_reg [3];
    logic signed [DOT_W-1:0] depth2_reg, numx_reg, numy_reg;
    logic                    rej2_reg;
    logic signed [PRJ_W-1:0] prodx_reg, prody_reg, prodx_next, prody_next;
    logic signed [DOT_W-1:0] depth3_reg;
    logic                    rej3_reg;
    logic [MAG_W-1:0]        magx_reg, magy_reg;
    logic                    negx4_reg, negy4_reg, rej4_reg;
    logic signed [DOT_W-1:0] depth4_reg;
    logic [REM_W-1:0]        nx_reg, ny_reg;
    logic                    negx5_reg, negy5_reg, rej5_reg;
    logic signed [DOT_W-1:0] depth5_reg;

    logic signed [COORD_BITS-1:0]       cam [3];
    logic signed [BASIS_FIELD_BITS-1:0] bn [3];
    logic signed [BASIS_FIELD_BITS-1:0] br [3];
    logic signed [BASIS_FIELD_BITS-1:0] bu [3];
    logic signed [COORD_BITS-1:0]       pt [3];
    logic signed [PSC_W:0]              psc_s;
    logic [LIMIT_W-1:0]                 limit;
    logic signed [DOT_W-1:0]            depth_next;
    logic [REM_W-1:0]                   den_top;

    always_comb begin
        pt[0] = in_data.point_x;
        pt[1] = in_data.point_y;
        pt[2] = in_data.point_z;
        for (int i = 0; i < 3; i++) begin
            cam[i] = cfg.cam_position[i*COORD_BITS +: COORD_BITS];
            bn[i]  = cfg.view_normal[i*BASIS_FIELD_BITS +: BASIS_FIELD_BITS];
            br[i]  = cfg.view_right[i*BASIS_FIELD_BITS +: BASIS_FIELD_BITS];
            bu[i]  = cfg.view_up[i*BASIS_FIELD_BITS +: BASIS_FIELD_BITS];
        end
        psc_s      = $signed({1'b0, cfg.proj_scale, {OUT_FRAC_BITS{1'b0}}});
        limit      = {cfg.min_depth, {BASIS_FRAC_BITS{1'b0}}};
        depth_next = DOT_W'(pn_reg[0]) + DOT_W'(pn_reg[1]) + DOT_W'(pn_reg[2]);
        prodx_next = numx_reg * psc_s;
        prody_next = numy_reg * psc_s;
        den_top    = REM_W'({depth5_reg, {QUOT_W{1'b0}}});
    end

    always_comb begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = ~vld_reg[k] | en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= D_W'(pt[i]) - D_W'(cam[i]);
            end
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                pn_reg[i] <= d_reg[i] * bn[i];
                pr_reg[i] <= d_reg[i] * br[i];
                pu_reg[i] <= d_reg[i] * bu[i];
            end
        end
        if (en[2]) begin
            depth2_reg <= depth_next;
            numx_reg   <= DOT_W'(pr_reg[0]) + DOT_W'(pr_reg[1]) + DOT_W'(pr_reg[2]);
            numy_reg   <= DOT_W'(pu_reg[0]) + DOT_W'(pu_reg[1]) + DOT_W'(pu_reg[2]);
            rej2_reg   <= depth_next <= $signed({{(DOT_W-LIMIT_W){1'b0}}, limit});
        end
        if (en[3]) begin
            prodx_reg  <= prodx_next;
            prody_reg  <= prody_next;
            depth3_reg <= depth2_reg;
            rej3_reg   <= rej2_reg;
        end
        if (en[4]) begin
            negx4_reg  <= prodx_reg[PRJ_W-1];
            negy4_reg  <= prody_reg[PRJ_W-1];
            magx_reg   <= prodx_reg[PRJ_W-1] ? MAG_W'(-prodx_reg) : MAG_W'(prodx_reg);
            magy_reg   <= prody_reg[PRJ_W-1] ? MAG_W'(-prody_reg) : MAG_W'(prody_reg);
            depth4_reg <= depth3_reg;
            rej4_reg   <= rej3_reg;
        end
        if (en[5]) begin
            nx_reg     <= REM_W'(magx_reg) + REM_W'(depth4_reg[DOT_W-1:1]);
            ny_reg     <= REM_W'(magy_reg) + REM_W'(depth4_reg[DOT_W-1:1]);
            negx5_reg  <= negx4_reg;
            negy5_reg  <= negy4_reg;
            depth5_reg <= depth4_reg;
            rej5_reg   <= rej4_reg;
        end
    end

    always_comb begin
        out_data.rem_x  = nx_reg;
        out_data.rem_y  = ny_reg;
        out_data.quot_x = '0;
        out_data.quot_y = '0;
        out_data.den    = depth5_reg;
        out_data.neg_x  = negx5_reg;
        out_data.neg_y  = negy5_reg;
        out_data.ovf_x  = nx_reg >= den_top;
        out_data.ovf_y  = ny_reg >= den_top;
        out_data.rej    = rej5_reg;
    end

endmodule

[src/ppp_div_cell.sv]
// ---------------------------------------------------------------------------
// Projector divider cell
// One restoring quotient bit per axis; hands the partial result onwards.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppp_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ppp_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ppp_pkg::div_t out_data
);
    import ppp_pkg::*;

    logic             vld_reg;
    div_t             data_reg, data_next;
    logic [REM_W-1:0] den_sh, rx, ry;
    logic             gex, gey;

    assign in_ready  = ~vld_reg | out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_comb begin
        den_sh    = REM_W'({in_data.den, {(QUOT_W-1){1'b0}}});
        gex       = in_data.rem_x >= den_sh;
        gey       = in_data.rem_y >= den_sh;
        rx        = gex ? in_data.rem_x - den_sh : in_data.rem_x;
        ry        = gey ? in_data.rem_y - den_sh : in_data.rem_y;
        data_next        = in_data;
        data_next.rem_x  = {rx[REM_W-2:0], 1'b0};
        data_next.rem_y  = {ry[REM_W-2:0], 1'b0};
        data_next.quot_x = {in_data.quot_x[QUOT_W-2:0], gex};
        data_next.quot_y = {in_data.quot_y[QUOT_W-2:0], gey};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) data_reg <= data_next;
    end

endmodule

[src/ppp_out.sv]
// ---------------------------------------------------------------------------
// Projector output stage
// Applies sign and centre offset, saturates, holds the result transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perspective_point_projector_defines.svh"
module ppp_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ppp_pkg::SCALE_W-1:0] center_x,
    input  logic [ppp_pkg::SCALE_W-1:0] center_y,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ppp_pkg::div_t              in_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ppp_pkg::result_t           m_data
);
    import ppp_pkg::*;

    logic    m_valid_reg;
    result_t m_data_reg, m_data_next;

    function automatic logic [SCREEN_W-1:0] axis_out(
        input logic [SCALE_W-1:0] ctr,
        input logic [QUOT_W-1:0]  quot,
        input logic               neg,
        input logic               ovf
    );
        logic [QUOT_W-1:0]       q;
        logic signed [RES_W-1:0] c, qs, r;
        logic                    hi_ok;
        q  = ovf ? '1 : quot;
        c  = $signed(RES_W'({ctr, {OUT_FRAC_BITS{1'b0}}}));
        qs = $signed(RES_W'(q));
        r  = neg ? c - qs : c + qs;
        hi_ok = (r[RES_W-1:SCREEN_W-1] == '0) || (r[RES_W-1:SCREEN_W-1] == '1);
        if (hi_ok) begin
            axis_out = r[SCREEN_W-1:0];
        end else begin
            axis_out = {r[RES_W-1], {(SCREEN_W-1){~r[RES_W-1]}}};
        end
    endfunction

    always_comb begin
        m_data_next.visible  = ~in_data.rej;
        m_data_next.screen_x = '0;
        m_data_next.screen_y = '0;
        if (!in_data.rej) begin
            m_data_next.screen_x = axis_out(center_x, in_data.quot_x, in_data.neg_x,
                                            in_data.ovf_x);
            m_data_next.screen_y = axis_out(center_y, in_data.quot_y, in_data.neg_y,
                                            in_data.ovf_y);
        end
    end

    assign in_ready = ~m_valid_reg | m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) m_data_reg <= m_data_next;
    end

    `PPP_ASSERT_NOW(a_hidden_zero, m_valid && !m_data.visible, m_data.screen_x == '0 && m_data.screen_y == '0)
    `PPP_ASSERT_NEXT(a_load_shows, in_valid && in_ready, m_valid)
    `PPP_ASSERT_NOW(a_stall_only_full, !in_ready, m_valid && !m_ready)

endmodule

[src/perspective_point_projector.sv]
// ---------------------------------------------------------------------------
// Perspective point projector
// Pinhole projection of world points to saturated Q12.4 screen coordinates.
// ---------------------------------------------------------------------------
// One point enters per clock unless the result side stalls; it passes six
// front stages (offset, basis products, dot sums and depth test, scale
// multiply, magnitude, rounding bias), a chain of 18 divider cells that each
// settle one quotient bit for both axes, and the output register. Stalls on
// the result side fill bubbles before they hold the input. Points at or
// below the minimum depth give zero coordinates with visible low.
// Configuration writes are always accepted.
`timescale 1ns / 1ps
module perspective_point_projector (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ppp_pkg::point_t               s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ppp_pkg::result_t              m_data
);
    import ppp_pkg::*;

    cfg_t cfg_reg;

    logic c_valid [QUOT_W+1];
    logic c_ready [QUOT_W+1];
    div_t c_data  [QUOT_W+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cam_position <= CAM_W'(60'd1097364144128);
            cfg_reg.view_normal  <= BASIS_W'(48'd1073741824);
            cfg_reg.view_up      <= BASIS_W'(48'd70368744177664);
            cfg_reg.view_right   <= BASIS_W'(48'd49152);
            cfg_reg.proj_scale   <= SCALE_W'(12'd480);
            cfg_reg.center_x     <= SCALE_W'(12'd960);
            cfg_reg.center_y     <= SCALE_W'(12'd540);
            cfg_reg.min_depth    <= MIN_DEPTH_W'(20'd1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_CAM_POSITION: cfg_reg.cam_position <= cfg_data[CAM_W-1:0];
                REG_VIEW_NORMAL:  cfg_reg.view_normal  <= cfg_data[BASIS_W-1:0];
                REG_VIEW_UP:      cfg_reg.view_up      <= cfg_data[BASIS_W-1:0];
                REG_VIEW_RIGHT:   cfg_reg.view_right   <= cfg_data[BASIS_W-1:0];
                REG_PROJ_SCALE:   cfg_reg.proj_scale   <= cfg_data[SCALE_W-1:0];
                REG_CENTER_X:     cfg_reg.center_x     <= cfg_data[SCALE_W-1:0];
                REG_CENTER_Y:     cfg_reg.center_y     <= cfg_data[SCALE_W-1:0];
                REG_MIN_DEPTH:    cfg_reg.min_depth    <= cfg_data[MIN_DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    ppp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_data  (c_data[0])
    );

    for (genvar g = 0; g < QUOT_W; g++) begin : g_cell
        ppp_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[g]),
            .in_ready  (c_ready[g]),
            .in_data   (c_data[g]),
            .out_valid (c_valid[g+1]),
            .out_ready (c_ready[g+1]),
            .out_data  (c_data[g+1])
        );
    end

    ppp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .center_x (cfg_reg.center_x),
        .center_y (cfg_reg.center_y),
        .in_valid (c_valid[QUOT_W]),
        .in_ready (c_ready[QUOT_W]),
        .in_data  (c_data[QUOT_W]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[verif/perspective_point_projector_tb.sv]
// ---------------------------------------------------------------------------
// Perspective point projector testbench
// Drives world points with random gaps and register writes, predicts each
// projected result in the bench and checks every output transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module perspective_point_projector_tb;
    import ppp_pkg::*;

    localparam int          CYCLE_LIMIT      = 600000;
    localparam int          PIPE_FLUSH       = 40;
    localparam logic [7:0]  CFG_IDX_UNMAPPED = 8'd200;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    point_t                s_data;
    logic                  m_valid;
    logic                  m_ready;
    result_t               m_data;

    // bench copy of the camera registers
    logic [CAM_W-1:0]       cam_pos;
    logic [BASIS_W-1:0]     basis_n, basis_u, basis_r;
    logic [SCALE_W-1:0]     focal, ctr_x, ctr_y;
    logic [MIN_DEPTH_W-1:0] near_lim;

    result_t pending_screen[$];
    int      cycles, mismatches, points_sent, results_seen, visible_seen, cfg_writes;
    bit      steady;

    perspective_point_projector dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_screen.size());
            $display("perspective_point_projector_tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    int stall_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b1;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_ready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    function automatic longint basis_dot(longint dx, longint dy, longint dz,
                                         logic [BASIS_W-1:0] b);
        return dx * longint'($signed(b[15:0])) + dy * longint'($signed(b[31:16]))
             + dz * longint'($signed(b[47:32]));
    endfunction

    function automatic logic [SCREEN_W-1:0] screen_axis(logic [SCALE_W-1:0] ctr,
                                                        longint num, longint den);
        longint prod, mag, q, r;
        prod = num * longint'({focal, 4'b0000});
        mag  = (prod < 0) ? -prod : prod;
        q    = (mag + (den >>> 1)) / den;
        r    = (prod < 0) ? -q : q;
        r   += longint'({ctr, 4'b0000});
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[SCREEN_W-1:0];
    endfunction

    function automatic result_t project_point(point_t p);
        longint  dx, dy, dz, depth;
        result_t res;
        dx = longint'(p.point_x) - longint'($signed(cam_pos[19:0]));
        dy = longint'(p.point_y) - longint'($signed(cam_pos[39:20]));
        dz = longint'(p.point_z) - longint'($signed(cam_pos[59:40]));
        depth = basis_dot(dx, dy, dz, basis_n);
        res = '0;
        if (depth > (longint'(near_lim) <<< BASIS_FRAC_BITS)) begin
            res.screen_x = screen_axis(ctr_x, basis_dot(dx, dy, dz, basis_r), depth);
            res.screen_y = screen_axis(ctr_y, basis_dot(dx, dy, dz, basis_u), depth);
            res.visible  = 1'b1;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_screen.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %p", m_data);
            end else begin
                result_t want;
                want = pending_screen.pop_front();
                if (m_data.visible) visible_seen++;
                if (m_data.screen_x !== want.screen_x || m_data.screen_y !== want.screen_y
                        || m_data.visible !== want.visible) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected x=%0d y=%0d vis=%0b, got x=%0d y=%0d vis=%0b",
                                 results_seen, want.screen_x, want.screen_y, want.visible,
                                 m_data.screen_x, m_data.screen_y, m_data.visible);
                end
            end
        end
    end

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_screen.size() != 0) @(posedge aclk);
        repeat (PIPE_FLUSH) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CAM_POSITION: cam_pos  = val[CAM_W-1:0];
            REG_VIEW_NORMAL:  basis_n  = val[BASIS_W-1:0];
            REG_VIEW_UP:      basis_u  = val[BASIS_W-1:0];
            REG_VIEW_RIGHT:   basis_r  = val[BASIS_W-1:0];
            REG_PROJ_SCALE:   focal    = val[SCALE_W-1:0];
            REG_CENTER_X:     ctr_x    = val[SCALE_W-1:0];
            REG_CENTER_Y:     ctr_y    = val[SCALE_W-1:0];
            REG_MIN_DEPTH:    near_lim = val[MIN_DEPTH_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_point(logic [19:0] x, logic [19:0] y, logic [19:0] z);
        int g;
        g = pick_gap();
        @(negedge aclk);
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{point_x: x, point_y: y, point_z: z};
        do @(posedge aclk); while (!s_ready);
        pending_screen.push_back(project_point(s_data));
        points_sent++;
    endtask

    function automatic logic [15:0] unit_axis();
        return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
    endfunction

    function automatic logic [BASIS_W-1:0] rand_basis();
        logic [BASIS_W-1:0] b;
        b = '0;
        case ($urandom_range(0, 3))
            0: b[15:0]  = unit_axis();
            1: b[31:16] = unit_axis();
            2: b[47:32] = unit_axis();
            default: b = BASIS_W'({$urandom, $urandom});
        endcase
        return b;
    endfunction

    task automatic test_reset_defaults();
        send_point(20'sd0, 20'sd0, 20'sd0);
        send_point(20'sd1024, 20'sd0, 20'sd512);
        send_point(-20'sd3000, 20'sd4096, -20'sd700);
        send_point(20'sd0, -20'sd2047, 20'sd0);   // depth exactly at the limit
        send_point(20'sd0, -20'sd2046, 20'sd0);   // just past the limit
        send_point(20'sd0, -20'sd2048, 20'sd0);   // edge-on
        send_point(20'sd0, -20'sd9000, 20'sd0);   // behind the camera
        send_point(20'sd500, -20'sd2046, 20'sd500); // saturates both axes
        wait_idle();
    endtask

    task automatic test_point_extremes();
        send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        send_point(20'h80000, 20'h80000, 20'h80000);
        send_point(20'h80000, 20'h7FFFF, 20'h80000);
        send_point(20'h7FFFF, 20'h7FFFF, 20'h80000);
        send_point(20'h80000, 20'h7FFFF, 20'h7FFFF);
        send_point(20'hFFFFF, 20'h00001, 20'hFFFFF);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_CAM_POSITION, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_VIEW_NORMAL,  64'hFFFF_0000_8000_7FFF);
        write_reg(REG_VIEW_UP,      64'hFFFF_7FFF_7FFF_7FFF);
        write_reg(REG_VIEW_RIGHT,   64'h0000_8000_8000_8000);
        write_reg(REG_PROJ_SCALE,   64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CENTER_X,     64'h0FFF);
        write_reg(REG_CENTER_Y,     64'h0);
        write_reg(REG_MIN_DEPTH,    64'h0);
        write_reg(CFG_IDX_UNMAPPED, 64'h1234_5678_9ABC_DEF0); // ignored
        send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        send_point(20'h80000, 20'h80000, 20'h80000);
        send_point(20'h00000, 20'h7FFFF, 20'h80000);
        send_point(20'h12345, 20'h6789A, 20'hBCDEF);
        wait_idle();
        write_reg(REG_MIN_DEPTH, 64'hFFFFF);
        write_reg(REG_PROJ_SCALE, 64'h0);
        send_point(20'h7FFFF, 20'h00000, 20'h00000);
        send_point(20'h80000, 20'h7FFFF, 20'h00000);
        wait_idle();
    endtask

    task automatic test_random_scenes();
        logic [19:0] cx, cy, cz;
        for (int phase = 0; phase < 7; phase++) begin
            steady = (phase == 3);
            if (phase > 0) begin
                write_reg(REG_CAM_POSITION, {$urandom, $urandom} >> $urandom_range(0, 12));
                write_reg(REG_VIEW_NORMAL, CFG_DATA_W'(rand_basis()));
                write_reg(REG_VIEW_UP, CFG_DATA_W'(rand_basis()));
                write_reg(REG_VIEW_RIGHT, CFG_DATA_W'(rand_basis()));
                write_reg(REG_PROJ_SCALE, $urandom_range(0, 1) ? 64'($urandom) : 64'd480);
                write_reg(REG_CENTER_X, 64'($urandom));
                write_reg(REG_CENTER_Y, 64'($urandom));
                write_reg(REG_MIN_DEPTH, $urandom_range(0, 3) == 0 ? 64'($urandom)
                                                                   : 64'($urandom_range(0, 64)));
            end
            for (int k = 0; k < 95; k++) begin
                if (phase == 2 && k == 50) wait_idle();
                if ($urandom_range(0, 99) < 40) begin
                    send_point(20'($urandom), 20'($urandom), 20'($urandom));
                end else begin
                    cx = cam_pos[19:0] + 20'($signed($urandom_range(0, 16383)) - 8192);
                    cy = cam_pos[39:20] + 20'($signed($urandom_range(0, 16383)) - 8192);
                    cz = cam_pos[59:40] + 20'($signed($urandom_range(0, 16383)) - 8192);
                    send_point(cx, cy, cz);
                end
            end
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        steady    = 1'b0;
        cam_pos   = 60'd1097364144128;
        basis_n   = 48'd1073741824;
        basis_u   = 48'd70368744177664;
        basis_r   = 48'd49152;
        focal     = 12'd480;
        ctr_x     = 12'd960;
        ctr_y     = 12'd540;
        near_lim  = 20'd1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_point_extremes();
        test_register_extremes();
        test_random_scenes();

        $display("%0d points projected under %0d register writes, %0d visible",
                 points_sent, cfg_writes, visible_seen);
        if (mismatches == 0 && pending_screen.size() == 0) begin
            $display("perspective_point_projector_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_screen.size());
            $display("perspective_point_projector_tb: FAIL");
        end
        $finish;
    end
endmodule
